// File: rtl/core/sacl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and codes of the set-associative cache model with LRU
// replacement: transaction payloads, access and outcome codes, register
// indexes and sequencer states.
// ----------------------------------------------------------------------------
package sacl_pkg;

   // Default structural limits, handed to the top level as parameters.
   localparam int DEF_MAX_SET_BITS = 8;
   localparam int DEF_MAX_WAYS     = 8;
   localparam int DEF_ADDR_WIDTH   = 32;

   // Register widths and reset values.
   localparam int SET_BITS_W    = 4;
   localparam int OFFSET_BITS_W = 5;
   localparam int WAYS_W        = 4;
   localparam int CSR_DATA_W    = 5;
   localparam int CSR_INDEX_W   = 2;

   localparam logic [SET_BITS_W-1:0]    SET_BITS_RESET    = 4'd4;
   localparam logic [OFFSET_BITS_W-1:0] OFFSET_BITS_RESET = 5'd4;
   localparam logic [WAYS_W-1:0]        WAYS_RESET        = 4'd1;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_SET_BITS    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_BITS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WAYS        = 2'd2;

   // Access codes.
   localparam logic [1:0] ACT_LOAD   = 2'd0;
   localparam logic [1:0] ACT_STORE  = 2'd1;
   localparam logic [1:0] ACT_MODIFY = 2'd2;

   // Outcome codes.
   localparam logic [1:0] OUT_HIT   = 2'd0;
   localparam logic [1:0] OUT_MISS  = 2'd1;
   localparam logic [1:0] OUT_EVICT = 2'd2;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] address;
   } req_type;

   typedef struct packed {
      logic [1:0]  outcome;
      logic [31:0] hit_total;
      logic [31:0] miss_total;
      logic [31:0] eviction_total;
      logic        last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EVAL
   } cache_state_type;

endpackage
`default_nettype wire

// File: rtl/core/set_assoc_cache_lru_model_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_model_unit
// Set-associative cache model with true LRU replacement and saturating
// hit, miss and eviction totals.
// ----------------------------------------------------------------------------
// Usage. Each request transaction carries one access (load, store or modify)
// and a byte address. A load or store yields one response transaction; a
// modify yields two, the second with last set. An unused access code is
// taken and yields nothing. The csr port sets the set index width, the
// block offset width and the number of ways in use; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// Sequence. A taken request reads its set row; in the evaluation state the
// updated row is written back and the response registered, and a modify
// then rereads the row for its second response. A new request is taken only
// once the block is idle again: each access is a read of its set row from
// the line memory followed by a write back of the updated row.
// Reset. After reset the block sweeps the line memory, one set row per
// cycle, clearing all 2**MAX_SET_BITS rows (256 at the default) and holding
// req_stall high; csr writes are taken during the sweep.
// Back-pressure. The response sits in an output register; while rsp_stall
// holds it, the next access waits in its evaluation cycle, but a new request
// may still be taken behind a waiting response.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_model_unit #(
   parameter int MAX_SET_BITS = sacl_pkg::DEF_MAX_SET_BITS,
   parameter int MAX_WAYS     = sacl_pkg::DEF_MAX_WAYS,
   parameter int ADDR_WIDTH   = sacl_pkg::DEF_ADDR_WIDTH
) (
   input  wire                                   clock,
   input  wire                                   reset,
   // Request channel
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  sacl_pkg::req_type                     req_data,
   // Response channel
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output sacl_pkg::rsp_type                     rsp_data,
   // Configuration port
   input  wire                                   csr_wen,
   input  wire  [sacl_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire  [sacl_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import sacl_pkg::*;

   localparam int SETS    = 1 << MAX_SET_BITS;
   localparam int RANK_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int CNT_W   = WAYS_W + 1;
   localparam int SHIFT_W = OFFSET_BITS_W + 2;

   typedef struct packed {
      logic              valid;
      logic [RANK_W-1:0] rank;
      logic [ADDR_WIDTH-1:0] tag;
   } line_type;

   typedef line_type [MAX_WAYS-1:0] row_type;

   // Line memory: one row per set, holding every way of that set.
   row_type line_mem [SETS];
   row_type rd_row_ff;

   // Configuration registers.
   logic [SET_BITS_W-1:0]    set_bits_ff;
   logic [OFFSET_BITS_W-1:0] offset_bits_ff;
   logic [WAYS_W-1:0]        ways_ff;

   // Control and payload registers.
   cache_state_type          state_ff, state_in;
   logic [MAX_SET_BITS-1:0]  clr_ff, clr_in;
   logic                     mod_ff, mod_in;
   logic [31:0]              addr_ff;
   logic [31:0]              hit_ff, hit_in;
   logic [31:0]              miss_ff, miss_in;
   logic [31:0]              evict_ff, evict_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   // Memory port controls.
   logic                     mem_re, mem_we;
   logic [MAX_SET_BITS-1:0]  mem_raddr, mem_waddr;
   row_type                  mem_wdata;

   // Address decode.
   logic [SET_BITS_W-1:0]    eff_sb;
   logic [CNT_W-1:0]         eff_ways;
   logic [MAX_WAYS-1:0]      in_use;
   logic [31:0]              acc_addr;
   logic [ADDR_WIDTH-1:0]    acc_addr_w, cur_addr_w, set_mask;
   logic [MAX_SET_BITS-1:0]  acc_set, cur_set;
   logic [ADDR_WIDTH-1:0]    cur_tag;

   // Evaluation of one access.
   logic [MAX_WAYS-1:0]      hit_vec, empty_vec;
   logic                     hit_any, empty_any;
   logic [WAY_W-1:0]         hit_way, empty_way, victim_way, sel_way;
   logic [RANK_W-1:0]        best_rank;
   logic [RANK_W:0]          old_rank;
   logic [1:0]               outcome;
   row_type                  new_row;
   logic                     fire, req_take;

   // -------------------------------------------------------------------------
   // Configuration registers
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff    <= SET_BITS_RESET;
         offset_bits_ff <= OFFSET_BITS_RESET;
         ways_ff        <= WAYS_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_SET_BITS:    set_bits_ff    <= csr_wdata[SET_BITS_W-1:0];
            CSR_OFFSET_BITS: offset_bits_ff <= csr_wdata[OFFSET_BITS_W-1:0];
            CSR_WAYS:        ways_ff        <= csr_wdata[WAYS_W-1:0];
            default: ;
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Address split. The set index is limited to MAX_SET_BITS bits and the
   // number of ways is clamped to the range one to MAX_WAYS.
   // -------------------------------------------------------------------------
   always_comb begin
      if (32'(set_bits_ff) > 32'(MAX_SET_BITS)) begin
         eff_sb = SET_BITS_W'(MAX_SET_BITS);
      end else begin
         eff_sb = set_bits_ff;
      end

      if (ways_ff == '0) begin
         eff_ways = CNT_W'(1);
      end else if (CNT_W'(ways_ff) > CNT_W'(MAX_WAYS)) begin
         eff_ways = CNT_W'(MAX_WAYS);
      end else begin
         eff_ways = CNT_W'(ways_ff);
      end

      for (int i = 0; i < MAX_WAYS; i++) begin
         in_use[i] = (CNT_W'(i) < eff_ways);
      end

      acc_addr   = (state_ff == ST_IDLE) ? req_data.address : addr_ff;
      acc_addr_w = ADDR_WIDTH'(acc_addr);
      cur_addr_w = ADDR_WIDTH'(addr_ff);
      set_mask   = ~({ADDR_WIDTH{1'b1}} << eff_sb);
      acc_set    = MAX_SET_BITS'((acc_addr_w >> offset_bits_ff) & set_mask);
      cur_set    = MAX_SET_BITS'((cur_addr_w >> offset_bits_ff) & set_mask);
      // A shift at or beyond the address width leaves a tag of zero.
      cur_tag    = cur_addr_w >> (SHIFT_W'(eff_sb) + SHIFT_W'(offset_bits_ff));
   end

   // -------------------------------------------------------------------------
   // Evaluation of the set row read for the current access: hit search,
   // first empty line, LRU victim and the rank update of the whole row.
   // -------------------------------------------------------------------------
   always_comb begin
      for (int i = 0; i < MAX_WAYS; i++) begin
         hit_vec[i]   = in_use[i] && rd_row_ff[i].valid && (rd_row_ff[i].tag == cur_tag);
         empty_vec[i] = in_use[i] && !rd_row_ff[i].valid;
      end
      hit_any   = |hit_vec;
      empty_any = |empty_vec;

      // Lowest index wins, so scan downwards.
      hit_way   = '0;
      empty_way = '0;
      for (int i = MAX_WAYS - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            hit_way = WAY_W'(i);
         end
         if (empty_vec[i]) begin
            empty_way = WAY_W'(i);
         end
      end

      // Greatest rank is evicted; a strict compare keeps the lowest index on a tie.
      victim_way = '0;
      best_rank  = rd_row_ff[0].rank;
      for (int i = 1; i < MAX_WAYS; i++) begin
         if (in_use[i] && (rd_row_ff[i].rank > best_rank)) begin
            best_rank  = rd_row_ff[i].rank;
            victim_way = WAY_W'(i);
         end
      end

      priority if (hit_any) begin
         sel_way  = hit_way;
         old_rank = {1'b0, rd_row_ff[hit_way].rank};
         outcome  = OUT_HIT;
      end else if (empty_any) begin
         sel_way  = empty_way;
         old_rank = (RANK_W + 1)'(MAX_WAYS);
         outcome  = OUT_MISS;
      end else begin
         sel_way  = victim_way;
         old_rank = {1'b0, best_rank};
         outcome  = OUT_EVICT;
      end

      new_row = rd_row_ff;
      for (int i = 0; i < MAX_WAYS; i++) begin
         if (WAY_W'(i) == sel_way) begin
            new_row[i].valid = 1'b1;
            new_row[i].rank  = '0;
            if (!hit_any) begin
               new_row[i].tag = cur_tag;
            end
         end else if (in_use[i] && rd_row_ff[i].valid &&
                      ({1'b0, rd_row_ff[i].rank} < old_rank) &&
                      (rd_row_ff[i].rank < RANK_W'(MAX_WAYS - 1))) begin
            new_row[i].rank = rd_row_ff[i].rank + RANK_W'(1);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Sequencer: next state, memory controls, totals and response register.
   // -------------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      mod_in       = mod_ff;
      hit_in       = hit_ff;
      miss_in      = miss_ff;
      evict_in     = evict_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_re       = 1'b0;
      mem_we       = 1'b0;
      mem_raddr    = acc_set;
      mem_waddr    = cur_set;
      mem_wdata    = new_row;
      req_stall    = (state_ff != ST_IDLE);
      req_take     = req_valid && !req_stall;
      fire         = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + MAX_SET_BITS'(1);
            if (clr_ff == {MAX_SET_BITS{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take && (req_data.action == ACT_LOAD ||
                             req_data.action == ACT_STORE ||
                             req_data.action == ACT_MODIFY)) begin
               mem_re   = 1'b1;
               mod_in   = (req_data.action == ACT_MODIFY);
               state_in = ST_EVAL;
            end
         end
         ST_READ: begin
            mem_re   = 1'b1;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            fire = !rsp_valid_ff || !rsp_stall;
            if (fire) begin
               mem_we = 1'b1;
               if (outcome == OUT_HIT) begin
                  hit_in = (hit_ff == '1) ? hit_ff : hit_ff + 32'd1;
               end else begin
                  miss_in = (miss_ff == '1) ? miss_ff : miss_ff + 32'd1;
               end
               if (outcome == OUT_EVICT) begin
                  evict_in = (evict_ff == '1) ? evict_ff : evict_ff + 32'd1;
               end
               rsp_valid_in                = 1'b1;
               rsp_data_in.outcome         = outcome;
               rsp_data_in.hit_total       = hit_in;
               rsp_data_in.miss_total      = miss_in;
               rsp_data_in.eviction_total  = evict_in;
               rsp_data_in.last            = !mod_ff;
               mod_in                      = 1'b0;
               // The second access of a modify rereads the row just written.
               state_in = mod_ff ? ST_READ : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         mod_ff       <= 1'b0;
         hit_ff       <= '0;
         miss_ff      <= '0;
         evict_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         mod_ff       <= mod_in;
         hit_ff       <= hit_in;
         miss_ff      <= miss_in;
         evict_ff     <= evict_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (req_take) begin
         addr_ff <= req_data.address;
      end
   end

   // Line memory: one write port, one read port with registered data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_row_ff <= line_mem[mem_raddr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // -------------------------------------------------------------------------
   // Assertions
   // -------------------------------------------------------------------------
   a_evict_not_above_miss: assert property (@(posedge clock) disable iff (reset)
      evict_ff <= miss_ff)
      else $error("eviction total exceeds miss total");

   a_modify_second_pass: assert property (@(posedge clock) disable iff (reset)
      (fire && mod_ff) |=> (state_ff == ST_READ))
      else $error("second access of a modify was not issued");

   a_hit_counted: assert property (@(posedge clock) disable iff (reset)
      (fire && outcome == OUT_HIT && hit_ff != '1) |=> (hit_ff == $past(hit_ff) + 32'd1))
      else $error("hit total not advanced on a hit");

   a_no_rsp_while_clearing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid_ff)
      else $error("response shown during the memory sweep");

endmodule
`default_nettype wire
